// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the scaler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PNS_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition that must never be seen outside reset.
`define PNS_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ===== rtl/pns_pkg.sv =====
// Shared types, constants and the palette function of the palette scaler.
package pns_pkg;

   // Largest source window that the scaler handles.
   localparam int MAX_SOURCE_WIDTH  = 256;
   localparam int MAX_SOURCE_HEIGHT = 256;

   // Depth of the job queue between front and back.
   localparam int JOB_DEPTH   = 4;
   localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
   localparam int JOB_COUNT_W = $clog2(JOB_DEPTH + 1);

   // Configuration port address width: seven 32-bit registers.
   localparam int CSR_ADDR_W = 5;

   // Register indexes in the configuration map.
   typedef enum logic [2:0] {
      REG_SRC_WIDTH   = 3'd0,
      REG_SRC_HEIGHT  = 3'd1,
      REG_DST_WIDTH   = 3'd2,
      REG_DST_HEIGHT  = 3'd3,
      REG_OFFSET_X    = 3'd4,
      REG_OFFSET_Y    = 3'd5,
      REG_SKIP_ENABLE = 3'd6
   } reg_index_type;

   // Configuration register set.
   typedef struct packed {
      logic [8:0] src_width;
      logic [8:0] src_height;
      logic [9:0] dst_width;
      logic [8:0] dst_height;
      logic [8:0] offset_x;
      logic [8:0] offset_y;
      logic       skip_enable;
   } cfg_type;

   // One source word.
   typedef struct packed {
      logic [7:0] color_index;
      logic       frame_start;
   } req_word_type;

   // One destination word.
   typedef struct packed {
      logic [15:0] pixel_rgb565;
      logic [9:0]  dest_col;
      logic [9:0]  dest_row;
      logic        row_end;
      logic        last_of_run;
   } rsp_word_type;

   // Work for the back end: one or two destination pixels of one source pixel.
   typedef struct packed {
      logic [15:0] pixel_rgb565;
      logic [9:0]  dest_col;
      logic [9:0]  dest_row;
      logic        two_pixels;
      logic        row_end_first;
      logic        row_end_second;
   } job_type;

   // Levels of the 3-3-2 palette.
   localparam logic [7:0] LEVEL3 [8] = '{8'h00, 8'h24, 8'h48, 8'h6C,
                                         8'h90, 8'hB4, 8'hD8, 8'hFF};
   localparam logic [7:0] LEVEL2 [4] = '{8'h00, 8'h48, 8'hB4, 8'hFF};

   // Palette index rrrgggbb to RGB565, keeping the top bits of each level.
   function automatic logic [15:0] palette565(input logic [7:0] idx);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = LEVEL3[idx[7:5]];
      g = LEVEL3[idx[4:2]];
      b = LEVEL2[idx[1:0]];
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

// ===== rtl/pns_csr.sv =====
// Configuration registers behind the APB-style port.
module pns_csr
   import pns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg,
   output logic                  cfg_write
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          write_strobe;
   logic          index_hit;
   reg_index_type index;

   assign csr_pready   = 1'b1;
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;
   assign index        = reg_index_type'(csr_paddr[4:2]);

   // Next register values and whether the address names a register.
   always_comb begin
      cfg_in    = cfg_ff;
      index_hit = 1'b1;
      case (index)
         REG_SRC_WIDTH:   cfg_in.src_width   = csr_pwdata[8:0];
         REG_SRC_HEIGHT:  cfg_in.src_height  = csr_pwdata[8:0];
         REG_DST_WIDTH:   cfg_in.dst_width   = csr_pwdata[9:0];
         REG_DST_HEIGHT:  cfg_in.dst_height  = csr_pwdata[8:0];
         REG_OFFSET_X:    cfg_in.offset_x    = csr_pwdata[8:0];
         REG_OFFSET_Y:    cfg_in.offset_y    = csr_pwdata[8:0];
         REG_SKIP_ENABLE: cfg_in.skip_enable = csr_pwdata[0];
         default:         index_hit          = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width   <= 9'd256;
         cfg_ff.src_height  <= 9'd192;
         cfg_ff.dst_width   <= 10'd240;
         cfg_ff.dst_height  <= 9'd135;
         cfg_ff.offset_x    <= 9'd0;
         cfg_ff.offset_y    <= 9'd0;
         cfg_ff.skip_enable <= 1'b1;
      end else if (write_strobe) begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (index)
         REG_SRC_WIDTH:   csr_prdata = {23'd0, cfg_ff.src_width};
         REG_SRC_HEIGHT:  csr_prdata = {23'd0, cfg_ff.src_height};
         REG_DST_WIDTH:   csr_prdata = {22'd0, cfg_ff.dst_width};
         REG_DST_HEIGHT:  csr_prdata = {23'd0, cfg_ff.dst_height};
         REG_OFFSET_X:    csr_prdata = {23'd0, cfg_ff.offset_x};
         REG_OFFSET_Y:    csr_prdata = {23'd0, cfg_ff.offset_y};
         REG_SKIP_ENABLE: csr_prdata = {31'd0, cfg_ff.skip_enable};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg       = cfg_ff;
   assign cfg_write = write_strobe && index_hit;

endmodule

// ===== rtl/pns_front.sv =====
// Front end: tracks source and destination positions and issues pixel jobs.
`include "assert_macros.svh"
module pns_front
   import pns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cfg_write,
   input  logic         in_accept,
   input  req_word_type in_word,
   output logic         job_push,
   output job_type      job
);

   logic [8:0]  source_column_ff, source_column_in;
   logic [8:0]  source_line_ff, source_line_in;
   logic [9:0]  next_dest_column_ff, next_dest_column_in;
   logic [8:0]  next_dest_line_ff, next_dest_line_in;
   logic [18:0] column_error_ff, column_error_in;
   logic [17:0] line_error_ff, line_error_in;
   logic        skip_phase_ff, skip_phase_in;

   logic [8:0]  sw, sh, dh;
   logic [9:0]  dw;
   logic [8:0]  sc, sl, ndl;
   logic [9:0]  ndc;
   logic [18:0] ce;
   logic [17:0] le;
   logic        row_here, keep, first_hit, second_hit;
   logic [19:0] ce_one, ce_two, ce_final;
   logic [9:0]  sc_next;
   logic [9:0]  sl_next;
   logic [18:0] le_sum;
   logic [10:0] ndc_wide;

   // Effective window sizes: zero reads as one, large values saturate.
   always_comb begin
      if (cfg.src_width == 9'd0) begin
         sw = 9'd1;
      end else if (int'(cfg.src_width) > MAX_SOURCE_WIDTH) begin
         sw = 9'(MAX_SOURCE_WIDTH);
      end else begin
         sw = cfg.src_width;
      end
      if (cfg.src_height == 9'd0) begin
         sh = 9'd1;
      end else if (int'(cfg.src_height) > MAX_SOURCE_HEIGHT) begin
         sh = 9'(MAX_SOURCE_HEIGHT);
      end else begin
         sh = cfg.src_height;
      end
      if (cfg.dst_width == 10'd0) begin
         dw = 10'd1;
      end else if (cfg.dst_width > {sw, 1'b0}) begin
         dw = {sw, 1'b0};
      end else begin
         dw = cfg.dst_width;
      end
      if (cfg.dst_height == 9'd0) begin
         dh = 9'd1;
      end else if (cfg.dst_height > sh) begin
         dh = sh;
      end else begin
         dh = cfg.dst_height;
      end
   end

   // Position seen by this word: a frame start begins from the origin.
   always_comb begin
      if (in_word.frame_start) begin
         sc  = '0;
         sl  = '0;
         ndc = '0;
         ndl = '0;
         ce  = '0;
         le  = '0;
      end else begin
         sc  = source_column_ff;
         sl  = source_line_ff;
         ndc = next_dest_column_ff;
         ndl = next_dest_line_ff;
         ce  = column_error_ff;
         le  = line_error_ff;
      end
   end

   // Row selection and the up to two destination columns of this pixel.
   assign row_here   = le < {9'd0, dh};
   assign keep       = row_here && !(cfg.skip_enable && (ndl[0] ^ skip_phase_ff));
   assign first_hit  = {1'b0, ce} < {10'd0, dw};
   assign ce_one     = {1'b0, ce} + {11'd0, sw};
   assign second_hit = first_hit && (ce_one < {10'd0, dw});
   assign ce_two     = ce_one + {11'd0, sw};
   assign ndc_wide   = {1'b0, ndc};

   always_comb begin
      if (second_hit) begin
         ce_final = ce_two;
      end else if (first_hit) begin
         ce_final = ce_one;
      end else begin
         ce_final = {1'b0, ce};
      end
   end

   // Job for the back end.
   always_comb begin
      job.pixel_rgb565   = palette565(in_word.color_index);
      job.dest_col       = ndc + {1'b0, cfg.offset_x};
      job.dest_row       = {1'b0, ndl} + {1'b0, cfg.offset_y};
      job.two_pixels     = second_hit;
      job.row_end_first  = (ndc_wide + 11'd1) == {1'b0, dw};
      job.row_end_second = (ndc_wide + 11'd2) == {1'b0, dw};
   end

   assign job_push = in_accept && keep && first_hit;

   // Position update after the word, with line and frame wrap.
   assign sc_next = {1'b0, sc} + 10'd1;
   assign sl_next = {1'b0, sl} + 10'd1;
   assign le_sum  = row_here ? ({1'b0, le} + {10'd0, sh}) : {1'b0, le};

   always_comb begin
      source_column_in    = source_column_ff;
      source_line_in      = source_line_ff;
      next_dest_column_in = next_dest_column_ff;
      next_dest_line_in   = next_dest_line_ff;
      column_error_in     = column_error_ff;
      line_error_in       = line_error_ff;
      skip_phase_in       = skip_phase_ff;
      if (cfg_write) begin
         source_column_in    = '0;
         source_line_in      = '0;
         next_dest_column_in = '0;
         next_dest_line_in   = '0;
         column_error_in     = '0;
         line_error_in       = '0;
      end else if (in_accept) begin
         source_column_in    = sc_next[8:0];
         source_line_in      = sl;
         next_dest_column_in = ndc + {9'd0, first_hit} + {9'd0, second_hit};
         next_dest_line_in   = ndl;
         line_error_in       = le;
         if (ce_final >= {10'd0, dw}) begin
            column_error_in = 19'(ce_final - {10'd0, dw});
         end else begin
            column_error_in = '0;
         end
         if (sc_next >= {1'b0, sw}) begin
            source_column_in    = '0;
            next_dest_column_in = '0;
            column_error_in     = '0;
            next_dest_line_in   = ndl + {8'd0, row_here};
            if (le_sum >= {10'd0, dh}) begin
               line_error_in = 18'(le_sum - {10'd0, dh});
            end else begin
               line_error_in = '0;
            end
            source_line_in = sl_next[8:0];
            if (sl_next >= {1'b0, sh}) begin
               source_line_in    = '0;
               next_dest_line_in = '0;
               line_error_in     = '0;
               skip_phase_in     = skip_phase_ff ^ cfg.skip_enable;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_column_ff    <= '0;
         source_line_ff      <= '0;
         next_dest_column_ff <= '0;
         next_dest_line_ff   <= '0;
         column_error_ff     <= '0;
         line_error_ff       <= '0;
         skip_phase_ff       <= 1'b0;
      end else begin
         source_column_ff    <= source_column_in;
         source_line_ff      <= source_line_in;
         next_dest_column_ff <= next_dest_column_in;
         next_dest_line_ff   <= next_dest_line_in;
         column_error_ff     <= column_error_in;
         line_error_ff       <= line_error_in;
         skip_phase_ff       <= skip_phase_in;
      end
   end

   // The source column always lies inside the window.
   `PNS_CHECK(a_column_in_window, source_column_ff < sw, "source column outside window")
   // The line counter wraps at the window height.
   `PNS_CHECK(a_line_in_window, source_line_ff < sh, "source line outside window")

endmodule

// ===== rtl/pns_job_fifo.sv =====
// Short queue of pixel jobs between the front and back ends.
`include "assert_macros.svh"
module pns_job_fifo
   import pns_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_COUNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = count_ff == JOB_COUNT_W'(JOB_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   // Pointer and fill-level update.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == JOB_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == JOB_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Fill level never passes the depth.
   `PNS_CHECK(a_count_bound, count_ff <= JOB_COUNT_W'(JOB_DEPTH), "job queue overfilled")
   // A lone push raises the fill level by one.
   `PNS_CHECK(a_count_push, (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1),
              "job queue count lost a push")

endmodule

// ===== rtl/pns_back.sv =====
// Back end: expands jobs into destination words on the output register.
`include "assert_macros.svh"
module pns_back
   import pns_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_type      head_job,
   input  logic         job_empty,
   output logic         job_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output rsp_word_type rsp_data
);

   rsp_word_type out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         second_ff, second_in;
   logic         load;

   // The output register takes a new word when free or being emptied.
   assign load = !out_valid_ff || rsp_pop;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      second_in    = second_ff;
      job_pop      = 1'b0;
      if (load) begin
         out_valid_in        = !job_empty;
         out_in.pixel_rgb565 = head_job.pixel_rgb565;
         out_in.dest_row     = head_job.dest_row;
         if (second_ff) begin
            out_in.dest_col    = head_job.dest_col + 10'd1;
            out_in.row_end     = head_job.row_end_second;
            out_in.last_of_run = 1'b1;
         end else begin
            out_in.dest_col    = head_job.dest_col;
            out_in.row_end     = head_job.row_end_first;
            out_in.last_of_run = !head_job.two_pixels;
         end
         if (!job_empty) begin
            if (!second_ff && head_job.two_pixels) begin
               second_in = 1'b1;
            end else begin
               second_in = 1'b0;
               job_pop   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // A half-done job stays at the head of the queue.
   `PNS_NEVER(a_second_has_job, second_ff && job_empty, "second pixel without a job")
   // The first word of a pair is shown before the second is due.
   `PNS_CHECK(a_second_after_word, second_ff |-> out_valid_ff, "pair split without a word")

endmodule

// ===== rtl/palette_nearest_scaler.sv =====
// Top level of the palette-indexed nearest-neighbour scaler.
// The scaler takes one palette-indexed source word per clock whenever the
// four-entry job queue has room, converts it to RGB565 and emits zero, one
// or two destination words with offset coordinates, row-end and run-end
// flags. A source word that maps to two destination columns sends both of
// its words through the single output register in turn, so the sustained
// rate, with rsp_pop held high, is one source word per cycle for downscaling
// and one output word per cycle for doubling, set by the port; and
// the job queue absorbs bursts between the two sides. Every configuration
// write restarts the position counters of the frame; no clearing pass is
// needed after reset.
module palette_nearest_scaler
   import pns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_word_type          req_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   logic    cfg_write;
   logic    in_accept;
   logic    job_push;
   job_type job;
   job_type head_job;
   logic    job_full;
   logic    job_empty;
   logic    job_pop;

   assign req_full  = job_full;
   assign in_accept = req_push && !job_full;

   pns_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_write   (cfg_write)
   );

   pns_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_write (cfg_write),
      .in_accept (in_accept),
      .in_word   (req_data),
      .job_push  (job_push),
      .job       (job)
   );

   pns_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (job_pop),
      .head_job (head_job),
      .full     (job_full),
      .empty    (job_empty)
   );

   pns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/palette_nearest_scaler_tb.sv =====
// Self-checking testbench of the palette-indexed nearest-neighbour scaler.
`timescale 1ns / 1ps

module testbench;
   import pns_pkg::*;

   // Cycles let pass after the last expected word before a register write.
   localparam int SETTLE_CYCLES = 20;
   // Cycles watched after the run for stray words.
   localparam int TAIL_CYCLES   = 40;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_WORDS   = 70;

   typedef enum logic [1:0] {
      ROW_WRITE   = 2'd0,
      ROW_PIXEL   = 2'd1,
      ROW_CHECKED = 2'd2
   } row_kind_type;

   // One line of the directed stimulus.
   typedef struct packed {
      row_kind_type  kind;
      reg_index_type reg_idx;
      logic [31:0]   value;
      req_word_type  word;
      rsp_word_type  known;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push    = 1'b0;
   logic                  req_full;
   req_word_type          req_data    = '0;
   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Shadow of the register set and of the position counters.
   cfg_type     shadow_cfg;
   logic [8:0]  src_col_pos;
   logic [8:0]  src_line_pos;
   logic [9:0]  next_col_pos;
   logic [8:0]  next_line_pos;
   logic [18:0] col_error;
   logic [17:0] line_error;
   logic        skip_phase_bit;

   rsp_word_type pending_pixels [$];
   stim_row_type directed_rows [$];
   int           mismatch_count = 0;
   bit           steady_finish  = 1'b0;
   bit           sender_gaps    = 1'b1;
   int           stall_left     = 0;
   int           quiet_left     = 0;

   palette_nearest_scaler dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 125 MHz clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Generous ceiling on the whole run.
   initial begin
      #2_000_000;
      $display("palette_nearest_scaler: mismatch");
      $finish;
   end

   // Red and green levels of the 3-3-2 palette.
   function automatic logic [7:0] tone_rg(input logic [2:0] code);
      case (code)
         3'd0: tone_rg = 8'h00;
         3'd1: tone_rg = 8'h24;
         3'd2: tone_rg = 8'h48;
         3'd3: tone_rg = 8'h6C;
         3'd4: tone_rg = 8'h90;
         3'd5: tone_rg = 8'hB4;
         3'd6: tone_rg = 8'hD8;
         default: tone_rg = 8'hFF;
      endcase
   endfunction

   // Blue levels of the 3-3-2 palette.
   function automatic logic [7:0] tone_b(input logic [1:0] code);
      case (code)
         2'd0: tone_b = 8'h00;
         2'd1: tone_b = 8'h48;
         2'd2: tone_b = 8'hB4;
         default: tone_b = 8'hFF;
      endcase
   endfunction

   function automatic logic [15:0] palette_colour(input logic [7:0] index);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      r = tone_rg(index[7:5]);
      g = tone_rg(index[4:2]);
      b = tone_b(index[1:0]);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   // Sizes as the scaler uses them: zero counts as one, large values saturate.
   function automatic void effective_sizes(input cfg_type c, output logic [10:0] sw,
                                           output logic [10:0] sh, output logic [10:0] dw,
                                           output logic [10:0] dh);
      sw = (c.src_width == 0) ? 11'd1 :
           (c.src_width > MAX_SOURCE_WIDTH) ? 11'(MAX_SOURCE_WIDTH) : 11'(c.src_width);
      sh = (c.src_height == 0) ? 11'd1 :
           (c.src_height > MAX_SOURCE_HEIGHT) ? 11'(MAX_SOURCE_HEIGHT) : 11'(c.src_height);
      dw = (c.dst_width == 0) ? 11'd1 : (c.dst_width > 2 * sw) ? 11'(2 * sw) : 11'(c.dst_width);
      dh = (c.dst_height == 0) ? 11'd1 : (c.dst_height > sh) ? sh : 11'(c.dst_height);
   endfunction

   function automatic void clear_position();
      src_col_pos   = '0;
      src_line_pos  = '0;
      next_col_pos  = '0;
      next_line_pos = '0;
      col_error     = '0;
      line_error    = '0;
   endfunction

   // Works out the destination words of one accepted source word and steps the counters.
   task automatic scale_source_word(input req_word_type w, input bit use_known,
                                    input rsp_word_type known);
      logic [10:0]  sw;
      logic [10:0]  sh;
      logic [10:0]  dw;
      logic [10:0]  dh;
      logic [15:0]  colour;
      logic         row_here;
      logic         keep;
      rsp_word_type pix [2];
      rsp_word_type one;
      int           n;
      effective_sizes(shadow_cfg, sw, sh, dw, dh);
      colour = palette_colour(w.color_index);
      n = 0;
      if (w.frame_start)
         clear_position();
      row_here = (line_error < dh);
      keep = row_here && !(shadow_cfg.skip_enable && (next_line_pos[0] ^ skip_phase_bit));

      // At most two destination columns fall on one source column.
      for (int k = 0; k < 2; k++) begin
         if (col_error < dw) begin
            if (keep) begin
               one.pixel_rgb565 = colour;
               one.dest_col     = next_col_pos + shadow_cfg.offset_x;
               one.dest_row     = next_line_pos + shadow_cfg.offset_y;
               one.row_end      = (next_col_pos + 1 == dw);
               one.last_of_run  = 1'b0;
               pix[n] = one;
               n++;
            end
            next_col_pos++;
            col_error = col_error + sw;
         end
      end

      if (use_known) begin
         pending_pixels.push_back(known);
      end else begin
         for (int k = 0; k < n; k++) begin
            one = pix[k];
            one.last_of_run = (k == n - 1);
            pending_pixels.push_back(one);
         end
      end

      // End of source line and end of frame.
      col_error = (col_error >= dw) ? col_error - dw : '0;
      src_col_pos++;
      if (src_col_pos >= sw) begin
         src_col_pos  = '0;
         next_col_pos = '0;
         col_error    = '0;
         if (row_here) begin
            next_line_pos++;
            line_error = line_error + sh;
         end
         line_error = (line_error >= dh) ? line_error - dh : '0;
         src_line_pos++;
         if (src_line_pos >= sh) begin
            clear_position();
            if (shadow_cfg.skip_enable)
               skip_phase_bit = ~skip_phase_bit;
         end
      end
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] wanted,
                                input logic [31:0] seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t %s: expected %h, got %h", $realtime, what, wanted, seen);
   endtask

   // Compares one popped word with the oldest expectation.
   task automatic check_result(input rsp_word_type got);
      rsp_word_type want;
      if (pending_pixels.size() == 0) begin
         note_mismatch("word with nothing expected", '0, {got.dest_row, got.dest_col});
      end else begin
         want = pending_pixels.pop_front();
         if (got.pixel_rgb565 !== want.pixel_rgb565)
            note_mismatch("pixel_rgb565", want.pixel_rgb565, got.pixel_rgb565);
         if (got.dest_col !== want.dest_col)
            note_mismatch("dest_col", want.dest_col, got.dest_col);
         if (got.dest_row !== want.dest_row)
            note_mismatch("dest_row", want.dest_row, got.dest_row);
         if (got.row_end !== want.row_end)
            note_mismatch("row_end", want.row_end, got.row_end);
         if (got.last_of_run !== want.last_of_run)
            note_mismatch("last_of_run", want.last_of_run, got.last_of_run);
      end
   endtask

   // Receiver: takes words, with random stalls and quiet stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            check_result(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else if (quiet_left > 0 || steady_finish) begin
            if (quiet_left > 0)
               quiet_left--;
            rsp_pop <= 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 12);
            rsp_pop <= 1'b0;
         end else begin
            if ($urandom_range(0, 63) == 0)
               quiet_left = $urandom_range(40, 200);
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic hold_sender(input int cycles);
      req_push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Offers one source word and waits until it is taken.
   task automatic send_source_word(input req_word_type w, input bit use_known,
                                   input rsp_word_type known);
      req_data <= w;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      scale_source_word(w, use_known, known);
      if (sender_gaps && !steady_finish && $urandom_range(0, 9) == 0)
         hold_sender($urandom_range(1, 13));
   endtask

   // Writes one register once the scaler has gone quiet, then reads it back.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] readback;
      hold_sender(0);
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);

      case (idx)
         REG_SRC_WIDTH: begin
            shadow_cfg.src_width = value[8:0];
            readback = {23'd0, value[8:0]};
         end
         REG_SRC_HEIGHT: begin
            shadow_cfg.src_height = value[8:0];
            readback = {23'd0, value[8:0]};
         end
         REG_DST_WIDTH: begin
            shadow_cfg.dst_width = value[9:0];
            readback = {22'd0, value[9:0]};
         end
         REG_DST_HEIGHT: begin
            shadow_cfg.dst_height = value[8:0];
            readback = {23'd0, value[8:0]};
         end
         REG_OFFSET_X: begin
            shadow_cfg.offset_x = value[8:0];
            readback = {23'd0, value[8:0]};
         end
         REG_OFFSET_Y: begin
            shadow_cfg.offset_y = value[8:0];
            readback = {23'd0, value[8:0]};
         end
         default: begin
            shadow_cfg.skip_enable = value[0];
            readback = {31'd0, value[0]};
         end
      endcase
      // Any write restarts the frame; the skip phase survives.
      clear_position();

      // Read the register back straight away.
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (csr_prdata !== readback)
         note_mismatch("register read back", readback, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_setting(input cfg_type c);
      write_register(REG_SRC_WIDTH,   {23'd0, c.src_width});
      write_register(REG_SRC_HEIGHT,  {23'd0, c.src_height});
      write_register(REG_DST_WIDTH,   {22'd0, c.dst_width});
      write_register(REG_DST_HEIGHT,  {23'd0, c.dst_height});
      write_register(REG_OFFSET_X,    {23'd0, c.offset_x});
      write_register(REG_OFFSET_Y,    {23'd0, c.offset_y});
      write_register(REG_SKIP_ENABLE, {31'd0, c.skip_enable});
   endtask

   // Mostly small windows so that frames complete; now and then zeros or saturation.
   task automatic pick_setting(output cfg_type c);
      int choice;
      int sw;
      choice = $urandom_range(0, 9);
      if (choice == 0) begin
         c.src_width  = $urandom_range(256, 511);
         c.src_height = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 2) :
                                                      $urandom_range(256, 511);
         c.dst_width  = $urandom_range(512, 1023);
         c.dst_height = $urandom_range(0, 511);
      end else if (choice == 1) begin
         c.src_width  = '0;
         c.src_height = '0;
         c.dst_width  = '0;
         c.dst_height = '0;
      end else begin
         sw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
         c.src_width  = sw;
         c.src_height = $urandom_range(1, 8);
         c.dst_width  = $urandom_range(0, 2 * sw + 2);
         c.dst_height = $urandom_range(0, c.src_height + 1);
      end
      c.offset_x    = $urandom_range(0, 511);
      c.offset_y    = $urandom_range(0, 511);
      c.skip_enable = $urandom_range(0, 1);
   endtask

   function automatic void add_write(input reg_index_type idx, input logic [31:0] value);
      stim_row_type row;
      row = '0;
      row.kind    = ROW_WRITE;
      row.reg_idx = idx;
      row.value   = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_pixel(input logic [7:0] index, input logic start);
      stim_row_type row;
      row = '0;
      row.kind             = ROW_PIXEL;
      row.word.color_index = index;
      row.word.frame_start = start;
      directed_rows.push_back(row);
   endfunction

   // A source word whose single destination word is written out by hand.
   function automatic void add_checked(input logic [7:0] index, input logic start,
                                       input logic [15:0] rgb, input logic [9:0] col,
                                       input logic [9:0] row_no, input logic last_in_row);
      stim_row_type row;
      row = '0;
      row.kind               = ROW_CHECKED;
      row.word.color_index   = index;
      row.word.frame_start   = start;
      row.known.pixel_rgb565 = rgb;
      row.known.dest_col     = col;
      row.known.dest_row     = row_no;
      row.known.row_end      = last_in_row;
      row.known.last_of_run  = 1'b1;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed_table();
      // Reset setting: palette extremes along the first line, then a frame start mid-line.
      add_checked(8'hFF, 1'b1, 16'hFFFF, 10'd0, 10'd0, 1'b0);
      add_checked(8'h00, 1'b0, 16'h0000, 10'd1, 10'd0, 1'b0);
      add_checked(8'hE0, 1'b0, 16'hF800, 10'd2, 10'd0, 1'b0);
      add_checked(8'h1C, 1'b0, 16'h07E0, 10'd3, 10'd0, 1'b0);
      add_checked(8'h03, 1'b0, 16'h001F, 10'd4, 10'd0, 1'b0);
      add_pixel(8'h5A, 1'b0);
      add_pixel(8'h96, 1'b1);

      // 3x2 doubled across, skipping on, largest offsets: two frames show the phase flip.
      add_write(REG_SRC_WIDTH, 32'd3);
      add_write(REG_SRC_HEIGHT, 32'd2);
      add_write(REG_DST_WIDTH, 32'd6);
      add_write(REG_DST_HEIGHT, 32'd2);
      add_write(REG_OFFSET_X, 32'd511);
      add_write(REG_OFFSET_Y, 32'd511);
      add_write(REG_SKIP_ENABLE, 32'd1);
      for (int i = 0; i < 12; i++)
         add_pixel(8'(i * 37 + 11), (i % 6) == 0);

      // All sizes zero: each source word is a whole frame of one pixel.
      add_write(REG_SRC_WIDTH, 32'd0);
      add_write(REG_SRC_HEIGHT, 32'd0);
      add_write(REG_DST_WIDTH, 32'd0);
      add_write(REG_DST_HEIGHT, 32'd0);
      add_write(REG_OFFSET_X, 32'd0);
      add_write(REG_OFFSET_Y, 32'd0);
      add_write(REG_SKIP_ENABLE, 32'd0);
      add_checked(8'hFF, 1'b1, 16'hFFFF, 10'd0, 10'd0, 1'b1);
      add_checked(8'h00, 1'b0, 16'h0000, 10'd0, 10'd0, 1'b1);

      // Oversized values saturate: widest source, destination twice as wide.
      add_write(REG_SRC_WIDTH, 32'd511);
      add_write(REG_SRC_HEIGHT, 32'd300);
      add_write(REG_DST_WIDTH, 32'd1023);
      for (int i = 0; i < 3; i++)
         add_pixel(8'(i * 85 + 40), i == 0);
   endfunction

   // Sender side: reset, directed table, then random phases.
   initial begin
      cfg_type      setting;
      req_word_type w;
      rsp_word_type unused;
      stim_row_type row;
      logic [10:0]  sw;
      logic [10:0]  sh;
      logic [10:0]  dw;
      logic [10:0]  dh;
      int           frame_len;
      int           pos;
      bit           noise_mode;

      shadow_cfg.src_width   = 9'd256;
      shadow_cfg.src_height  = 9'd192;
      shadow_cfg.dst_width   = 10'd240;
      shadow_cfg.dst_height  = 9'd135;
      shadow_cfg.offset_x    = '0;
      shadow_cfg.offset_y    = '0;
      shadow_cfg.skip_enable = 1'b1;
      clear_position();
      skip_phase_bit = 1'b0;
      unused = '0;
      build_directed_table();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         case (row.kind)
            ROW_WRITE:   write_register(row.reg_idx, row.value);
            ROW_CHECKED: send_source_word(row.word, 1'b1, row.known);
            default:     send_source_word(row.word, 1'b0, unused);
         endcase
      end

      // Random phases; the last one runs without idling on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1)
            steady_finish = 1'b1;
         pick_setting(setting);
         write_setting(setting);
         effective_sizes(setting, sw, sh, dw, dh);
         frame_len   = sw * sh;
         noise_mode  = ($urandom_range(0, 3) == 0);
         sender_gaps = ($urandom_range(0, 3) != 0);
         pos = 0;
         repeat (PHASE_WORDS) begin
            w.color_index = $urandom_range(0, 255);
            if (noise_mode) begin
               w.frame_start = ($urandom_range(0, 15) == 0);
            end else begin
               // Well-formed frames, now and then cut short by an early frame start.
               if ($urandom_range(0, 49) == 0)
                  pos = 0;
               w.frame_start = (pos == 0);
            end
            pos = (pos + 1) % frame_len;
            send_source_word(w, 1'b0, unused);
         end
      end

      hold_sender(0);
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("palette_nearest_scaler: match");
      else
         $display("palette_nearest_scaler: mismatch");
      $finish;
   end

endmodule
